### rtl/core/touch_pad_baseline_detector_macros.svh
// Assertion helpers shared by the touch pad detector RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef TOUCH_PAD_BASELINE_DETECTOR_MACROS_SVH
`define TOUCH_PAD_BASELINE_DETECTOR_MACROS_SVH

// Same-cycle implication.
`define TPBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TPBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/tpbd_pkg.sv
package tpbd_pkg;

    localparam int PadWidth   = 3;
    localparam int CountWidth = 17;
    localparam int ThrWidth   = 16;
    localparam int RepWidth   = 4;
    localparam int PadCount   = 8;
    localparam int ScaleShift = 8;     // 8.8 threshold: count is scaled by 256
    localparam int ProdWidth  = ThrWidth + CountWidth;
    localparam int AddrWidth  = 3;
    localparam int DataWidth  = 32;

    localparam logic [RepWidth-1:0]   RepeatMax      = '1;
    localparam logic [CountWidth-1:0] CountInit      = '1;
    localparam logic [ThrWidth-1:0]   ThresholdReset = 16'd384;
    localparam logic [RepWidth-1:0]   RepeatsReset   = 4'd8;

    // Register select codes (paddr bit 2)
    localparam logic RegThreshold = 1'b0;
    localparam logic RegRepeats   = 1'b1;

    typedef struct packed {
        logic [ThrWidth-1:0] threshold;
        logic [RepWidth-1:0] repeats;
    } cfg_t;

    // Per-pad state update request
    typedef struct packed {
        logic                  en;
        logic [PadWidth-1:0]   pad;
        logic [CountWidth-1:0] count;
    } upd_t;

endpackage

### rtl/core/tpbd_cfg.sv
`include "touch_pad_baseline_detector_macros.svh"

module tpbd_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tpbd_pkg::AddrWidth-1:0] paddr,
    input  logic [tpbd_pkg::DataWidth-1:0] pwdata,
    output logic [tpbd_pkg::DataWidth-1:0] prdata,
    output tpbd_pkg::cfg_t                cfg
);

    tpbd_pkg::cfg_t cfg_reg;
    tpbd_pkg::cfg_t cfg_next;
    logic           wr_en;
    logic           reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[tpbd_pkg::AddrWidth-1];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                tpbd_pkg::RegThreshold:
                    cfg_next.threshold = pwdata[tpbd_pkg::ThrWidth-1:0];
                tpbd_pkg::RegRepeats:
                    cfg_next.repeats = pwdata[tpbd_pkg::RepWidth-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            tpbd_pkg::RegThreshold:
                prdata = tpbd_pkg::DataWidth'(cfg_reg.threshold);
            tpbd_pkg::RegRepeats:
                prdata = tpbd_pkg::DataWidth'(cfg_reg.repeats);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold <= tpbd_pkg::ThresholdReset;
            cfg_reg.repeats   <= tpbd_pkg::RepeatsReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

    `TPBD_ASSERT_NEXT(a_cfg_hold, !wr_en, $stable(cfg_reg), "config changed without a write")

endmodule

### rtl/core/tpbd_state.sv
`include "touch_pad_baseline_detector_macros.svh"

module tpbd_state
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  tpbd_pkg::upd_t                   upd,
    input  logic [tpbd_pkg::RepWidth-1:0]    repeats,
    output logic [tpbd_pkg::CountWidth-1:0]  base_new
);

    logic [tpbd_pkg::CountWidth-1:0] base_reg [tpbd_pkg::PadCount];
    logic [tpbd_pkg::RepWidth-1:0]   rep_reg  [tpbd_pkg::PadCount];
    logic [tpbd_pkg::CountWidth-1:0] prev_reg [tpbd_pkg::PadCount];

    logic [tpbd_pkg::CountWidth-1:0] base_cur;
    logic [tpbd_pkg::RepWidth-1:0]   rep_cur;
    logic                            same;
    logic [tpbd_pkg::RepWidth-1:0]   rep_inc;
    logic                            base_wr;
    logic [tpbd_pkg::CountWidth-1:0] base_next;
    logic [tpbd_pkg::RepWidth-1:0]   rep_next;

    assign base_cur = base_reg[upd.pad];
    assign rep_cur  = rep_reg[upd.pad];
    assign same     = (upd.count == prev_reg[upd.pad]);
    // saturating advance
    assign rep_inc  = (rep_cur == tpbd_pkg::RepeatMax) ? tpbd_pkg::RepeatMax
                                                        : rep_cur + 1'b1;
    assign rep_next  = same ? rep_inc : '0;
    assign base_wr   = same && (rep_inc == repeats) && (upd.count < base_cur);
    assign base_next = base_wr ? upd.count : base_cur;
    // judged against the baseline as it stands after this count
    assign base_new  = base_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tpbd_pkg::PadCount; i++)
            begin
                base_reg[i] <= tpbd_pkg::CountInit;
                rep_reg[i]  <= tpbd_pkg::RepeatMax;
                prev_reg[i] <= tpbd_pkg::CountInit;
            end
        end
        else if (upd.en)
        begin
            base_reg[upd.pad] <= base_next;
            rep_reg[upd.pad]  <= rep_next;
            prev_reg[upd.pad] <= upd.count;
        end
    end

    `TPBD_ASSERT_IMP(a_base_lowers, upd.en && base_wr, base_next < base_cur, "baseline rose")

endmodule

### rtl/core/tpbd_cmp.sv
module tpbd_cmp
(
    input  logic [tpbd_pkg::CountWidth-1:0] count,
    input  logic [tpbd_pkg::CountWidth-1:0] base,
    input  logic [tpbd_pkg::ThrWidth-1:0]   threshold,
    output logic                            touched
);

    logic [tpbd_pkg::CountWidth+tpbd_pkg::ScaleShift-1:0] lhs;
    logic [tpbd_pkg::ProdWidth-1:0]                       rhs;

    // full-width product, never wraps
    assign lhs = {count, tpbd_pkg::ScaleShift'(0)};
    assign rhs = tpbd_pkg::ProdWidth'(threshold) * tpbd_pkg::ProdWidth'(base);
    assign touched = (tpbd_pkg::ProdWidth'(lhs) > rhs);

endmodule

### rtl/core/touch_pad_baseline_detector.sv
// An accepted request moves through s1, s2 and the result register before its result shows.
// Throughput: one request per cycle; each pipeline stage moves whenever the next has room.
// Per-pad state sits in flip-flops and is read and written by the one state stage.
// Reset (rst_n, async, low) empties the pipeline, sets baseline and previous count
// to all ones, repeat counters to 15, threshold to 384 and repeats to 8.
`include "touch_pad_baseline_detector_macros.svh"

module touch_pad_baseline_detector
(
    input  logic        clk,
    input  logic        rst_n,
    // slave stream: [2:0] pad_index, [19:3] discharge_count, [23:20] zero
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    // master stream: [2:0] pad_number, [3] touched, [7:4] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = tpbd_pkg::PadWidth;
    localparam int CW = tpbd_pkg::CountWidth;

    // Three registered stages: input (s1), state update (s2), result (out).
    // Ready flows backward stage by stage so bubbles are filled even while
    // the result register waits on the sink.
    logic          s1_valid_reg, s1_valid_next;
    logic [PW-1:0] s1_pad_reg;
    logic [CW-1:0] s1_count_reg;

    logic          s2_valid_reg, s2_valid_next;
    logic [PW-1:0] s2_pad_reg;
    logic [CW-1:0] s2_count_reg;
    logic [CW-1:0] s2_base_reg;

    logic          out_valid_reg, out_valid_next;
    logic [PW-1:0] out_pad_reg;
    logic          out_touched_reg;

    logic rdy_out, rdy2, rdy1;
    logic take_in, mv12, mv2o;

    tpbd_pkg::cfg_t  cfg;
    tpbd_pkg::upd_t  upd;
    logic [CW-1:0]   base_new;
    logic            touched;

    assign rdy_out = !out_valid_reg || m_axis_tready;
    assign rdy2    = !s2_valid_reg || rdy_out;
    assign rdy1    = !s1_valid_reg || rdy2;

    assign take_in = s_axis_tvalid && rdy1;
    assign mv12    = s1_valid_reg && rdy2;
    assign mv2o    = s2_valid_reg && rdy_out;

    assign s_axis_tready = rdy1;
    assign pready        = 1'b1;

    tpbd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // State is touched exactly when an item leaves s1, so the next item
    // for the same pad always sees the updated entry.
    assign upd.en    = mv12;
    assign upd.pad   = s1_pad_reg;
    assign upd.count = s1_count_reg;

    tpbd_state u_state
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .upd      (upd),
        .repeats  (cfg.repeats),
        .base_new (base_new)
    );

    // Multiply and compare sit alone between s2 and the result register.
    tpbd_cmp u_cmp
    (
        .count     (s2_count_reg),
        .base      (s2_base_reg),
        .threshold (cfg.threshold),
        .touched   (touched)
    );

    assign s1_valid_next  = take_in ? 1'b1 : (rdy2 ? 1'b0 : s1_valid_reg);
    assign s2_valid_next  = mv12 ? 1'b1 : (rdy_out ? 1'b0 : s2_valid_reg);
    assign out_valid_next = mv2o ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s1_pad_reg   <= s_axis_tdata[PW-1:0];
            s1_count_reg <= s_axis_tdata[PW+CW-1:PW];
        end
        if (mv12)
        begin
            s2_pad_reg   <= s1_pad_reg;
            s2_count_reg <= s1_count_reg;
            s2_base_reg  <= base_new;
        end
        if (mv2o)
        begin
            out_pad_reg     <= s2_pad_reg;
            out_touched_reg <= touched;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_touched_reg, out_pad_reg};

    `TPBD_ASSERT_IMP(a_empty_ready, !s1_valid_reg, s_axis_tready, "empty input stage refused a request")
    `TPBD_ASSERT_NEXT(a_s1_to_s2, s1_valid_reg && rdy2, s2_valid_reg, "request lost between stages")

endmodule

### tb/touch_pad_baseline_detector_tb.sv
`timescale 1ns / 1ps

module touch_pad_baseline_detector_tb;

    localparam int CountMax = 100000;     // top of the measured count range
    localparam logic [tpbd_pkg::AddrWidth-1:0] AddrThreshold = {tpbd_pkg::RegThreshold, 2'b00};
    localparam logic [tpbd_pkg::AddrWidth-1:0] AddrRepeats   = {tpbd_pkg::RegRepeats, 2'b00};

    // One expected result: the echoed pad and the touch decision.
    typedef struct packed {
        logic [tpbd_pkg::PadWidth-1:0] pad;
        logic                          touched;
    } pad_result_t;

    // Per-pad calibration predictor plus the queue of results it predicts.
    class pad_scoreboard;
        logic [tpbd_pkg::CountWidth-1:0] baseline     [tpbd_pkg::PadCount];
        logic [tpbd_pkg::RepWidth-1:0]   repeats_seen [tpbd_pkg::PadCount];
        logic [tpbd_pkg::CountWidth-1:0] last_count   [tpbd_pkg::PadCount];
        logic [tpbd_pkg::ThrWidth-1:0]   threshold;
        logic [tpbd_pkg::RepWidth-1:0]   repeats_needed;
        pad_result_t                     expected_q[$];
        int                              errors;

        function new();
            for (int p = 0; p < tpbd_pkg::PadCount; p++)
            begin
                baseline[p]     = tpbd_pkg::CountInit;
                repeats_seen[p] = tpbd_pkg::RepeatMax;
                last_count[p]   = tpbd_pkg::CountInit;
            end
            threshold      = tpbd_pkg::ThresholdReset;
            repeats_needed = tpbd_pkg::RepeatsReset;
            errors         = 0;
        endfunction

        // Update the pad state for an accepted request and queue its result.
        function void note_request(logic [tpbd_pkg::PadWidth-1:0] pad,
                                   logic [tpbd_pkg::CountWidth-1:0] count);
            logic [tpbd_pkg::RepWidth-1:0] run;
            logic [63:0]                   scaled_count;
            logic [63:0]                   scaled_base;
            pad_result_t                   res;
            res.pad     = pad;
            res.touched = 1'b0;
            if (int'(pad) < tpbd_pkg::PadCount)
            begin
                if (count == last_count[pad])
                begin
                    // counter saturates at its top value
                    run = (repeats_seen[pad] == tpbd_pkg::RepeatMax) ? tpbd_pkg::RepeatMax
                                                                     : repeats_seen[pad] + 1'b1;
                    repeats_seen[pad] = run;
                    if (run == repeats_needed && count < baseline[pad])
                        baseline[pad] = count;
                end
                else
                begin
                    repeats_seen[pad] = '0;
                end
                last_count[pad] = count;
                scaled_count = 64'(count) << tpbd_pkg::ScaleShift;
                scaled_base  = 64'(threshold) * 64'(baseline[pad]);
                res.touched  = (scaled_count > scaled_base);
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [tpbd_pkg::PadWidth-1:0] pad, logic touched);
            pad_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("result with no request pending: pad_number=%0d touched=%0d",
                       pad, touched);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (pad !== exp_res.pad)
            begin
                $error("pad_number mismatch: expected %0d, got %0d", exp_res.pad, pad);
                errors++;
            end
            if (touched !== exp_res.touched)
            begin
                $error("touched mismatch: expected %0d, got %0d", exp_res.touched, touched);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;     // [2:0] pad_index, [19:3] discharge_count, [23:20] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // [2:0] pad_number, [3] touched, [7:4] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pad_scoreboard board;
    int            burst_left = 0;   // requests left in the current sender burst
    int            rx_hold    = 0;   // cycles the receiver still holds off

    touch_pad_baseline_detector dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Sender: bursts of random length, random gaps in between. A gap of zero
    // keeps tvalid high, so it is never lowered and raised in one step.
    task automatic send_request(input logic [tpbd_pkg::PadWidth-1:0] pad,
                                input logic [tpbd_pkg::CountWidth-1:0] count);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, count, pad};
        do @(posedge clk); while (s_axis_tready !== 1'b1);
        board.note_request(pad, count);
        burst_left--;
    endtask

    // Stop sending and wait for every predicted result, then let the
    // pipeline settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where pready is seen with penable.
    task automatic reg_write(input logic [tpbd_pkg::AddrWidth-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Both registers are rewritten with junk in the unused upper bits, which
    // the block must mask off.
    task automatic set_config(input logic [tpbd_pkg::ThrWidth-1:0] thr,
                              input logic [tpbd_pkg::RepWidth-1:0] reps);
        logic [31:0] junk;
        drain();
        junk = $urandom();
        reg_write(AddrThreshold, {junk[31:tpbd_pkg::ThrWidth], thr});
        board.threshold = thr;
        junk = $urandom();
        reg_write(AddrRepeats, {junk[31:tpbd_pkg::RepWidth], reps});
        board.repeats_needed = reps;
    endtask

    // Mostly calibration runs: one pad, one count, repeated about as often as
    // the repeat setting asks, then probes, about half near the touch boundary. The rest
    // is noise on random pads, which also breaks runs now and then.
    task automatic run_phase(input int n_items);
        int                              sent;
        int                              runs;
        int                              probes;
        longint                          edge_count;
        logic [tpbd_pkg::PadWidth-1:0]   pad;
        logic [tpbd_pkg::CountWidth-1:0] cal;
        logic [tpbd_pkg::CountWidth-1:0] count;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) < 8)
            begin
                pad = tpbd_pkg::PadWidth'($urandom());
                cal = ($urandom_range(0, 2) == 0)
                    ? tpbd_pkg::CountWidth'($urandom_range(0, CountMax))
                    : tpbd_pkg::CountWidth'($urandom_range(0, 4000));
                runs = int'(board.repeats_needed) + $urandom_range(0, 3);
                runs = (runs < 2) ? 2 : runs;
                for (int k = 0; k < runs; k++)
                begin
                    send_request(pad, cal);
                    sent++;
                    if ($urandom_range(0, 7) == 0)
                    begin
                        send_request(tpbd_pkg::PadWidth'($urandom()),
                                     tpbd_pkg::CountWidth'($urandom_range(0, CountMax)));
                        sent++;
                    end
                end
                probes = $urandom_range(1, 3);
                for (int k = 0; k < probes; k++)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        // just below, at, or just above threshold * calibrated count
                        edge_count = (longint'(cal) * longint'(board.threshold))
                                     >>> tpbd_pkg::ScaleShift;
                        edge_count = edge_count + longint'($urandom_range(0, 2)) - 1;
                        if (edge_count < 0)
                            edge_count = 0;
                        if (edge_count > CountMax)
                            edge_count = CountMax;
                        count = edge_count[tpbd_pkg::CountWidth-1:0];
                    end
                    else
                    begin
                        count = tpbd_pkg::CountWidth'($urandom_range(0,
                                    (2 * int'(cal) > CountMax) ? CountMax : 2 * int'(cal)));
                    end
                    send_request(pad, count);
                    sent++;
                end
            end
            else
            begin
                count = ($urandom_range(0, 15) == 0)
                      ? tpbd_pkg::CountInit
                      : tpbd_pkg::CountWidth'($urandom_range(0, CountMax));
                send_request(tpbd_pkg::PadWidth'($urandom()), count);
                sent++;
            end
        end
    endtask

    // Receiver: ready pattern changes mode every so often; a hold request
    // from the stimulus side forces a long stretch of back-pressure.
    initial
    begin
        int rx_mode;
        int rx_mode_left;
        rx_mode       = 0;
        rx_mode_left  = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
                board.check_result(m_axis_tdata[tpbd_pkg::PadWidth-1:0],
                                   m_axis_tdata[tpbd_pkg::PadWidth]);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(16, 200);
                end
                rx_mode_left--;
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Main stimulus.
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        board         = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings. A count of all ones matches the reset previous
        // count, so the saturated repeat counter stays at its top.
        send_request(3'd1, tpbd_pkg::CountInit);
        send_request(3'd0, '0);
        send_request(3'd7, tpbd_pkg::CountWidth'(CountMax));
        // nine equal counts: run of eight calibrates the baseline to 1000
        for (int k = 0; k < 9; k++)
            send_request(3'd2, 17'd1000);
        send_request(3'd2, 17'd1501);   // 1.5x plus one: touched
        send_request(3'd2, 17'd1500);   // exactly on the boundary: not touched

        // zero threshold, single repeat
        set_config('0, 4'd1);
        send_request(3'd4, 17'd7);
        send_request(3'd4, 17'd7);
        send_request(3'd4, '0);
        send_request(3'd4, 17'd1);

        // repeats of zero never calibrate
        set_config(tpbd_pkg::ThresholdReset, '0);
        send_request(3'd2, 17'd1500);
        send_request(3'd2, 17'd1500);

        // full-scale threshold; repeats of fifteen with a saturated counter
        set_config('1, tpbd_pkg::RepeatMax);
        send_request(3'd1, tpbd_pkg::CountInit);
        send_request(3'd6, tpbd_pkg::CountWidth'(CountMax));

        // Random phases over a spread of settings, extremes included.
        set_config('0, 4'd1);
        run_phase(300);

        // long receiver hold while the sender keeps offering back to back
        set_config('1, 4'd14);
        rx_hold    = 150;
        burst_left = 80;
        run_phase(300);

        set_config(tpbd_pkg::ThrWidth'($urandom()), tpbd_pkg::RepeatMax);
        run_phase(300);

        // sender pauses mid-phase until the pipeline is empty
        set_config(tpbd_pkg::ThrWidth'($urandom()),
                   tpbd_pkg::RepWidth'($urandom_range(1, 14)));
        run_phase(150);
        drain();
        run_phase(150);

        set_config(tpbd_pkg::ThresholdReset, '0);
        run_phase(300);

        set_config(tpbd_pkg::ThrWidth'($urandom_range(128, 1024)),
                   tpbd_pkg::RepWidth'($urandom_range(0, 15)));
        run_phase(300);

        drain();
        repeat (8) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("touch_pad_baseline_detector regression: pass");
        else
            $display("touch_pad_baseline_detector regression: fail");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("touch_pad_baseline_detector regression: fail");
        $finish;
    end

endmodule

### touch_pad_baseline_detector.f
+incdir+rtl/core
rtl/core/tpbd_pkg.sv
rtl/core/tpbd_cfg.sv
rtl/core/tpbd_state.sv
rtl/core/tpbd_cmp.sv
rtl/core/touch_pad_baseline_detector.sv
tb/touch_pad_baseline_detector_tb.sv
